// ===== hw/rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_HOLDS(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Condition that must be followed by another one on the next clock edge.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/hsl2rgb_pkg.sv =====
package hsl2rgb_pkg;

  localparam int FracBitsDefault = 12;

  typedef struct packed {
    logic mul_en;
    logic out_en;
  } ramp_ctrl_t;

endpackage

// ===== hw/rtl/hsl2rgb_prep.sv =====
module hsl2rgb_prep #(
  parameter int FRAC_BITS = hsl2rgb_pkg::FracBitsDefault
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [FRAC_BITS-1:0] hue,
  input  logic [FRAC_BITS:0]   sat,
  input  logic [FRAC_BITS:0]   light,
  output logic [FRAC_BITS:0]   sat_r,
  output logic [FRAC_BITS:0]   light_r,
  output logic [FRAC_BITS+1:0] t_red_r,
  output logic [FRAC_BITS+1:0] t_green_r,
  output logic [FRAC_BITS+1:0] t_blue_r
);

  localparam int TW = FRAC_BITS + 2;
  localparam logic [FRAC_BITS:0] VOne = (FRAC_BITS+1)'(2 ** FRAC_BITS);
  localparam logic [TW-1:0] One = TW'(2 ** FRAC_BITS);
  localparam logic [TW-1:0] TwoOne = TW'(2 * (2 ** FRAC_BITS));
  localparam logic [TW-1:0] Turn = TW'(3 * (2 ** FRAC_BITS));

  logic [FRAC_BITS:0] sat_nxt;
  logic [FRAC_BITS:0] light_nxt;
  logic [TW-1:0]      h3;
  logic [TW-1:0]      red_sum;
  logic [TW-1:0]      t_red_nxt;
  logic [TW-1:0]      t_blue_nxt;

  // Hue is scaled by three so that a third of a turn is exactly one unit.
  always_comb begin
    sat_nxt    = (sat > VOne) ? VOne : sat;
    light_nxt  = (light > VOne) ? VOne : light;
    h3         = {2'b00, hue} + {1'b0, hue, 1'b0};
    red_sum    = h3 + One;
    t_red_nxt  = (red_sum >= Turn) ? (red_sum - Turn) : red_sum;
    t_blue_nxt = (h3 >= One) ? (h3 - One) : (h3 + TwoOne);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sat_r     <= sat_nxt;
      light_r   <= light_nxt;
      t_red_r   <= t_red_nxt;
      t_green_r <= h3;
      t_blue_r  <= t_blue_nxt;
    end
  end

endmodule

// ===== hw/rtl/hsl2rgb_chroma.sv =====
module hsl2rgb_chroma #(
  parameter int FRAC_BITS = hsl2rgb_pkg::FracBitsDefault
) (
  input  logic               clk,
  input  logic               en,
  input  logic [FRAC_BITS:0] sat,
  input  logic [FRAC_BITS:0] light,
  output logic [FRAC_BITS:0] p_r,
  output logic [FRAC_BITS:0] q_r
);

  localparam int PW = 2 * FRAC_BITS + 2;
  localparam int QW = FRAC_BITS + 3;
  localparam logic [PW-1:0] HalfP = PW'(2 ** (FRAC_BITS - 1));
  localparam logic [FRAC_BITS:0] HalfV = (FRAC_BITS+1)'(2 ** (FRAC_BITS - 1));
  localparam logic [QW-1:0] OneQ = QW'(2 ** FRAC_BITS);

  logic [PW-1:0] prod;
  logic [PW-1:0] prod_rnd;
  logic [QW-1:0] m_e;
  logic [QW-1:0] l_e;
  logic [QW-1:0] s_e;
  logic [QW-1:0] q_raw;
  logic [QW-1:0] q_nxt;
  logic [QW-1:0] p_nxt;

  // For low lightness, round(L*(1+S)) equals L plus round(L*S) because L*1 is exact.
  always_comb begin
    prod     = PW'(light) * PW'(sat);
    prod_rnd = prod + HalfP;
    m_e      = QW'(prod_rnd[PW-1:FRAC_BITS]);
    l_e      = QW'(light);
    s_e      = QW'(sat);
    if (light < HalfV) begin
      q_raw = l_e + m_e;
    end else begin
      q_raw = l_e + s_e - m_e;
    end
    q_nxt = (q_raw > OneQ) ? OneQ : q_raw;
    if (q_nxt < l_e) begin
      q_nxt = l_e;
    end
    p_nxt = (l_e << 1) - q_nxt;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= q_nxt[FRAC_BITS:0];
      p_r <= p_nxt[FRAC_BITS:0];
    end
  end

endmodule

// ===== hw/rtl/hsl2rgb_ramp.sv =====
module hsl2rgb_ramp #(
  parameter int FRAC_BITS = hsl2rgb_pkg::FracBitsDefault
) (
  input  logic                   clk,
  input  hsl2rgb_pkg::ramp_ctrl_t ctrl,
  input  logic [FRAC_BITS:0]     p,
  input  logic [FRAC_BITS:0]     q,
  input  logic [FRAC_BITS+1:0]   t,
  output logic [FRAC_BITS:0]     chan_r
);

  localparam int TW = FRAC_BITS + 2;
  localparam int PW = 2 * FRAC_BITS + 2;
  localparam logic [TW-1:0] HalfT = TW'(2 ** (FRAC_BITS - 1));
  localparam logic [TW-1:0] ThreeHalfT = TW'(3 * (2 ** (FRAC_BITS - 1)));
  localparam logic [TW-1:0] TwoOneT = TW'(2 * (2 ** FRAC_BITS));
  localparam logic [PW-1:0] HalfP = PW'(2 ** (FRAC_BITS - 1));
  localparam logic [TW-1:0] OneS = TW'(2 ** FRAC_BITS);

  typedef enum logic [1:0] {
    RegRise,
    RegHigh,
    RegFall,
    RegLow
  } region_t;

  logic [FRAC_BITS:0] d;
  logic [FRAC_BITS:0] factor;
  logic [TW-1:0]      fall_dist;
  region_t            region_nxt;
  logic [PW-1:0]      prod_nxt;

  region_t            region_r;
  logic [PW-1:0]      prod_r;
  logic [FRAC_BITS:0] p_r;
  logic [FRAC_BITS:0] q_r;

  logic [PW-1:0]      prod_rnd;
  logic [TW-1:0]      sum;
  logic [TW-1:0]      val;
  logic [FRAC_BITS:0] chan_nxt;

  always_comb begin
    d          = q - p;
    fall_dist  = TwoOneT - t;
    factor     = '0;
    region_nxt = RegLow;
    if (t < HalfT) begin
      region_nxt = RegRise;
      factor     = (FRAC_BITS+1)'({t, 1'b0});
    end else if (t < ThreeHalfT) begin
      region_nxt = RegHigh;
    end else if (t < TwoOneT) begin
      region_nxt = RegFall;
      factor     = (FRAC_BITS+1)'({fall_dist, 1'b0});
    end
    prod_nxt = PW'(d) * PW'(factor);
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      region_r <= region_nxt;
      prod_r   <= prod_nxt;
      p_r      <= p;
      q_r      <= q;
    end
  end

  always_comb begin
    prod_rnd = prod_r + HalfP;
    sum      = TW'(p_r) + TW'(prod_rnd[PW-1:FRAC_BITS]);
    case (region_r)
      RegRise: val = sum;
      RegFall: val = sum;
      RegHigh: val = TW'(q_r);
      RegLow:  val = TW'(p_r);
      default: val = TW'(p_r);
    endcase
    chan_nxt = (val > OneS) ? OneS[FRAC_BITS:0] : val[FRAC_BITS:0];
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_en) begin
      chan_r <= chan_nxt;
    end
  end

endmodule

// ===== hw/rtl/hsl_to_rgb_converter_core.sv =====
// Flow: a transaction accepted into the first stage moves through each later stage in turn to the output.
// Throughput: one transaction per cycle while out_ready does not stall the output; the four register
// stages (hue scaling, chroma multiply, ramp multiply, round and saturate) each hold under stall.
// Each stage takes new data whenever it is empty or its successor advances.
// Reset: synchronous, active low; it clears the stage valid bits only, not the data.
`include "assert_macros.svh"

module hsl_to_rgb_converter_core #(
  parameter int FRAC_BITS = hsl2rgb_pkg::FracBitsDefault
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [FRAC_BITS-1:0] in_hue,
  input  logic [FRAC_BITS:0]   in_saturation,
  input  logic [FRAC_BITS:0]   in_lightness,
  input  logic [FRAC_BITS:0]   in_alpha_in,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [FRAC_BITS:0]   out_red,
  output logic [FRAC_BITS:0]   out_green,
  output logic [FRAC_BITS:0]   out_blue,
  output logic [FRAC_BITS:0]   out_alpha_out
);

  import hsl2rgb_pkg::*;

  localparam logic [FRAC_BITS:0] VOne = (FRAC_BITS+1)'(2 ** FRAC_BITS);

  logic v1_r, v2_r, v3_r, v4_r;
  logic v1_nxt, v2_nxt, v3_nxt, v4_nxt;
  logic adv1, adv2, adv3, adv4;

  logic [FRAC_BITS:0]   a1_r, a2_r, a3_r, a4_r;
  logic [FRAC_BITS:0]   sat1, light1;
  logic [FRAC_BITS+1:0] t_red1, t_green1, t_blue1;
  logic [FRAC_BITS+1:0] t_red2_r, t_green2_r, t_blue2_r;
  logic [FRAC_BITS:0]   p2, q2;
  ramp_ctrl_t           ramp_ctrl;
  logic                 chan_ok;
  logic                 pq_ok;

  always_comb begin
    adv4   = !v4_r || out_ready;
    adv3   = !v3_r || adv4;
    adv2   = !v2_r || adv3;
    adv1   = !v1_r || adv2;
    v1_nxt = adv1 ? in_valid : v1_r;
    v2_nxt = adv2 ? v1_r : v2_r;
    v3_nxt = adv3 ? v2_r : v3_r;
    v4_nxt = adv4 ? v3_r : v4_r;
    ramp_ctrl.mul_en = adv3;
    ramp_ctrl.out_en = adv4;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
      v4_r <= v4_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      a1_r <= in_alpha_in;
    end
    if (adv2) begin
      a2_r       <= a1_r;
      t_red2_r   <= t_red1;
      t_green2_r <= t_green1;
      t_blue2_r  <= t_blue1;
    end
    if (adv3) begin
      a3_r <= a2_r;
    end
    if (adv4) begin
      a4_r <= a3_r;
    end
  end

  hsl2rgb_prep #(.FRAC_BITS(FRAC_BITS)) u_prep (
    .clk       (clk),
    .en        (adv1),
    .hue       (in_hue),
    .sat       (in_saturation),
    .light     (in_lightness),
    .sat_r     (sat1),
    .light_r   (light1),
    .t_red_r   (t_red1),
    .t_green_r (t_green1),
    .t_blue_r  (t_blue1)
  );

  hsl2rgb_chroma #(.FRAC_BITS(FRAC_BITS)) u_chroma (
    .clk   (clk),
    .en    (adv2),
    .sat   (sat1),
    .light (light1),
    .p_r   (p2),
    .q_r   (q2)
  );

  hsl2rgb_ramp #(.FRAC_BITS(FRAC_BITS)) u_ramp_red (
    .clk    (clk),
    .ctrl   (ramp_ctrl),
    .p      (p2),
    .q      (q2),
    .t      (t_red2_r),
    .chan_r (out_red)
  );

  hsl2rgb_ramp #(.FRAC_BITS(FRAC_BITS)) u_ramp_green (
    .clk    (clk),
    .ctrl   (ramp_ctrl),
    .p      (p2),
    .q      (q2),
    .t      (t_green2_r),
    .chan_r (out_green)
  );

  hsl2rgb_ramp #(.FRAC_BITS(FRAC_BITS)) u_ramp_blue (
    .clk    (clk),
    .ctrl   (ramp_ctrl),
    .p      (p2),
    .q      (q2),
    .t      (t_blue2_r),
    .chan_r (out_blue)
  );

  assign in_ready      = adv1;
  assign out_valid     = v4_r;
  assign out_alpha_out = a4_r;

  assign chan_ok = (out_red <= VOne) && (out_green <= VOne) && (out_blue <= VOne);
  assign pq_ok   = (p2 <= q2) && (q2 <= VOne);

  `ASSERT_HOLDS(a_out_range, clk, rst_n, !out_valid || chan_ok, "Channel above full scale.")
  `ASSERT_HOLDS(a_pq_order, clk, rst_n, !v2_r || pq_ok, "Chroma stage out of order.")
  `ASSERT_NEXT(a_accept_fills, clk, rst_n, in_valid && in_ready, v1_r, "Transaction lost.")

endmodule
